>>> rtl/sorted_priority_list_insert_core_macros.svh
// assertion macros for the sorted priority list core
// used by the controller; needs clk and rst in scope
`ifndef SORTED_PRIORITY_LIST_INSERT_CORE_MACROS_SVH
`define SORTED_PRIORITY_LIST_INSERT_CORE_MACROS_SVH

// implication checked on every edge outside reset
`define SPLI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spli check failed");

// next-cycle implication checked outside reset
`define SPLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spli sequence check failed");

`endif

>>> rtl/spli_pkg.sv
// shared types and codes for the sorted priority list core
// no dependencies
package spli_pkg;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_UPDATE = 2'd2,
    ST_OUT    = 2'd3
  } state_t;

  localparam logic [1:0] STATUS_INSERTED = 2'd0;
  localparam logic [1:0] STATUS_IMPROVED = 2'd1;
  localparam logic [1:0] STATUS_KEPT     = 2'd2;
  localparam logic [1:0] STATUS_DROPPED  = 2'd3;

  localparam int COUNT_OUT_BITS = 7;

  typedef struct packed {
    logic capture;  // latch request and clear nothing else
    logic search;   // register per-cell compare flags
    logic update;   // apply shift and load in the cell row
  } cmd_t;

endpackage

>>> rtl/spli_ifs.sv
// valid/ready channel interfaces for requests and results
// depends on spli_pkg
interface spli_in_if #(
  parameter int ID_BITS   = 32,
  parameter int PRIO_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [ID_BITS-1:0]   node_id;
  logic [PRIO_BITS-1:0] priority_req;

  modport source (output valid, node_id, priority_req, input ready);
  modport sink (input valid, node_id, priority_req, output ready);
endinterface

interface spli_out_if #(
  parameter int ID_BITS   = 32,
  parameter int PRIO_BITS = 16
);
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [ID_BITS-1:0]                  head_node;
  logic [PRIO_BITS-1:0]                head_priority;
  logic [spli_pkg::COUNT_OUT_BITS-1:0] entry_count;

  modport source (output valid, status, head_node, head_priority, entry_count,
                  input ready);
  modport sink (input valid, status, head_node, head_priority, entry_count,
                output ready);
endinterface

>>> rtl/spli_ctrl.sv
// controller state machine for the sorted priority list core
// depends on spli_pkg and the macros header
`include "sorted_priority_list_insert_core_macros.svh"

module spli_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output spli_pkg::cmd_t  cmd
);

  spli_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spli_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      spli_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = spli_pkg::ST_SEARCH;
        end
      end
      spli_pkg::ST_SEARCH: begin
        cmd.search = 1'b1;
        state_next = spli_pkg::ST_UPDATE;
      end
      spli_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = spli_pkg::ST_OUT;
      end
      spli_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = spli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spli_pkg::ST_IDLE;
      end
    endcase
  end

  `SPLI_ASSERT_IMP(a_no_overlap, in_ready, !out_valid)
  `SPLI_ASSERT_NEXT(a_capture_then_search, cmd.capture, cmd.search)
  `SPLI_ASSERT_NEXT(a_search_then_update, cmd.search, cmd.update)
  `SPLI_ASSERT_NEXT(a_update_then_result, cmd.update, out_valid)

endmodule

>>> rtl/spli_datapath.sv
// row of compare-and-shift cells holding the sorted list
// depends on spli_pkg
module spli_datapath #(
  parameter int CAPACITY  = 64,
  parameter int ID_BITS   = 32,
  parameter int PRIO_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spli_pkg::cmd_t                      cmd,
  input  logic [ID_BITS-1:0]                  req_id,
  input  logic [PRIO_BITS-1:0]                req_prio,
  output logic [1:0]                          status,
  output logic [ID_BITS-1:0]                  head_node,
  output logic [PRIO_BITS-1:0]                head_priority,
  output logic [spli_pkg::COUNT_OUT_BITS-1:0] entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [ID_BITS-1:0]   ids [CAPACITY];
  logic [PRIO_BITS-1:0] pris [CAPACITY];
  logic [ID_BITS-1:0]   ids_next [CAPACITY];
  logic [PRIO_BITS-1:0] pris_next [CAPACITY];
  logic [CNT_W-1:0]     count, count_next;
  logic [ID_BITS-1:0]   cur_id;
  logic [PRIO_BITS-1:0] cur_prio;
  logic [CAPACITY-1:0]  match_vec, gt_vec, valid_vec;
  logic [CAPACITY-1:0]  match_now, gt_now, ge_p, upd;
  logic [1:0]           status_next;
  logic                 found, improve, full;

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      valid_vec[j] = CNT_W'(j) < count;
      match_now[j] = valid_vec[j] && (ids[j] == cur_id);
      gt_now[j]    = valid_vec[j] && (cur_prio < pris[j]);
    end
  end

  assign found   = |match_vec;
  assign improve = |(match_vec & gt_vec);
  assign full    = count == CNT_W'(CAPACITY);

  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      ge_p[j] = gt_vec[j] || !valid_vec[j];
      if (found) begin
        upd[j] = |(match_vec >> j);
      end else begin
        upd[j] = CNT_W'(j) <= count;
      end
    end
  end

  // each cell keeps its value, loads the request at the sorted slot or takes its left neighbor
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      ids_next[j]  = ids[j];
      pris_next[j] = pris[j];
    end
    if (cmd.update && (improve || (!found && !full))) begin
      // head cell has no left neighbor
      if (upd[0] && ge_p[0]) begin
        ids_next[0]  = cur_id;
        pris_next[0] = cur_prio;
      end
      for (int j = 1; j < CAPACITY; j++) begin
        if (upd[j]) begin
          if (ge_p[j] && !ge_p[j-1]) begin
            ids_next[j]  = cur_id;
            pris_next[j] = cur_prio;
          end else if (ge_p[j-1]) begin
            ids_next[j]  = ids[j-1];
            pris_next[j] = pris[j-1];
          end
        end
      end
    end
  end

  always_comb begin
    count_next  = count;
    if (found) begin
      status_next = improve ? spli_pkg::STATUS_IMPROVED : spli_pkg::STATUS_KEPT;
    end else if (full) begin
      status_next = spli_pkg::STATUS_DROPPED;
    end else begin
      status_next = spli_pkg::STATUS_INSERTED;
      count_next  = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < CAPACITY; j++) begin
      ids[j]  <= ids_next[j];
      pris[j] <= pris_next[j];
    end
    if (cmd.capture) begin
      cur_id   <= req_id;
      cur_prio <= req_prio;
    end
    if (cmd.search) begin
      match_vec <= match_now;
      gt_vec    <= gt_now;
    end
    if (cmd.update) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.update) begin
      count <= count_next;
    end
  end

  logic [CNT_W+spli_pkg::COUNT_OUT_BITS-1:0] count_wide;
  assign count_wide    = {{spli_pkg::COUNT_OUT_BITS{1'b0}}, count};
  assign entry_count   = count_wide[spli_pkg::COUNT_OUT_BITS-1:0];
  assign head_node     = ids[0];
  assign head_priority = pris[0];

endmodule

>>> rtl/sorted_priority_list_insert_core.sv
// sorted priority list with decrease-key: one request in, one result out
// the search and update states lie between request transfer and result valid;
// one item at a time: capture, compare row, shift row, result, then idle
// the compare and shift passes run once each across the whole cell row
// reset clears the entry count and the controller; cell contents are unset
module sorted_priority_list_insert_core #(
  parameter int CAPACITY  = 64,
  parameter int ID_BITS   = 32,
  parameter int PRIO_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  spli_in_if.sink    in_ch,
  spli_out_if.source out_ch
);

  // command bundle from controller to cell row
  spli_pkg::cmd_t cmd;

  // controller sequences capture, compare, shift and result transfer
  spli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // cell row holds the list; head cell and count feed the result directly
  spli_datapath #(
    .CAPACITY  (CAPACITY),
    .ID_BITS   (ID_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .req_id        (in_ch.node_id),
    .req_prio      (in_ch.priority_req),
    .status        (out_ch.status),
    .head_node     (out_ch.head_node),
    .head_priority (out_ch.head_priority),
    .entry_count   (out_ch.entry_count)
  );

endmodule

>>> sim/tb_sorted_priority_list_insert_core.sv
// testbench for the sorted priority list core: directed table then random traffic
// depends on spli_pkg, spli_ifs and the core rtl
`timescale 1ns / 100ps

module tb_sorted_priority_list_insert_core;

  localparam int CAP       = 64;
  localparam int ID_W      = 32;
  localparam int PRIO_W    = 16;
  localparam int N_RANDOM  = 1430;
  localparam int MAX_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spli_in_if  #(.ID_BITS(ID_W), .PRIO_BITS(PRIO_W)) in_ch ();
  spli_out_if #(.ID_BITS(ID_W), .PRIO_BITS(PRIO_W)) out_ch ();

  sorted_priority_list_insert_core #(
    .CAPACITY(CAP), .ID_BITS(ID_W), .PRIO_BITS(PRIO_W)
  ) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   head_node;
    logic [PRIO_W-1:0] head_priority;
    logic [6:0]        entry_count;
  } list_result_t;

  // shadow copy of the list, kept sorted by ascending priority
  logic [ID_W-1:0]   shadow_ids [CAP];
  logic [PRIO_W-1:0] shadow_prios [CAP];
  int                shadow_count;

  list_result_t expected_results[$];
  int           error_count;
  int           cycle_count;
  bit           inputs_done;
  bit           long_holdoff;

  // ids used by the random part, so repeats and improvements are common
  logic [ID_W-1:0] id_pool [$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  // first place in [0, limit) holding a priority strictly above prio
  function automatic int place_after_ties(input logic [PRIO_W-1:0] prio, input int limit);
    int j;
    for (j = 0; j < limit; j++)
      if (prio < shadow_prios[j]) return j;
    return limit;
  endfunction

  // apply one offer to the shadow list and work out its result
  function automatic list_result_t apply_offer(input logic [ID_W-1:0] id,
                                               input logic [PRIO_W-1:0] prio);
    list_result_t r;
    int hit;
    int p;
    hit = -1;
    for (int i = 0; i < shadow_count; i++)
      if (hit < 0 && shadow_ids[i] == id) hit = i;
    if (hit >= 0) begin
      if (prio < shadow_prios[hit]) begin
        p = place_after_ties(prio, hit);
        for (int j = hit; j > p; j--) begin
          shadow_ids[j]   = shadow_ids[j-1];
          shadow_prios[j] = shadow_prios[j-1];
        end
        shadow_ids[p]   = id;
        shadow_prios[p] = prio;
        r.status = spli_pkg::STATUS_IMPROVED;
      end else begin
        r.status = spli_pkg::STATUS_KEPT;
      end
    end else if (shadow_count >= CAP) begin
      r.status = spli_pkg::STATUS_DROPPED;
    end else begin
      p = place_after_ties(prio, shadow_count);
      for (int j = shadow_count; j > p; j--) begin
        shadow_ids[j]   = shadow_ids[j-1];
        shadow_prios[j] = shadow_prios[j-1];
      end
      shadow_ids[p]   = id;
      shadow_prios[p] = prio;
      shadow_count++;
      r.status = spli_pkg::STATUS_INSERTED;
    end
    r.head_node     = (shadow_count > 0) ? shadow_ids[0] : '0;
    r.head_priority = (shadow_count > 0) ? shadow_prios[0] : '0;
    r.entry_count   = shadow_count[6:0];
    return r;
  endfunction

  // directed table; typed-in results only where obvious, else predictor only
  typedef struct {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    bit                typed;
    list_result_t      want;
  } offer_row_t;

  offer_row_t directed[] = '{
    // first entry on an empty list becomes the head
    '{32'h0000_0005, 16'h0100, 1'b1,
      '{spli_pkg::STATUS_INSERTED, 32'h5, 16'h0100, 7'd1}},
    // all-ones id at the worst priority goes to the back
    '{32'hFFFF_FFFF, 16'hFFFF, 1'b1,
      '{spli_pkg::STATUS_INSERTED, 32'h5, 16'h0100, 7'd2}},
    // zero id at the best priority takes the head
    '{32'h0000_0000, 16'h0000, 1'b1,
      '{spli_pkg::STATUS_INSERTED, 32'h0, 16'h0000, 7'd3}},
    // same id, higher priority: kept
    '{32'h0000_0005, 16'h0200, 1'b1,
      '{spli_pkg::STATUS_KEPT, 32'h0, 16'h0000, 7'd3}},
    // same id, equal priority: kept
    '{32'h0000_0005, 16'h0100, 1'b1,
      '{spli_pkg::STATUS_KEPT, 32'h0, 16'h0000, 7'd3}},
    // ties land after equal entries
    '{32'h0000_0007, 16'h0100, 1'b0, '{default: '0}},
    '{32'h0000_0008, 16'h0100, 1'b0, '{default: '0}},
    // improvement moves the entry past others, after ties at the new priority
    '{32'hFFFF_FFFF, 16'h0100, 1'b0, '{default: '0}},
    '{32'h0000_0008, 16'h0001, 1'b0, '{default: '0}},
    // improvement to zero after the zero entry
    '{32'h0000_0007, 16'h0000, 1'b0, '{default: '0}},
    '{32'hA5A5_5A5A, 16'h5A5A, 1'b0, '{default: '0}},
    '{32'h5A5A_A5A5, 16'hA5A5, 1'b0, '{default: '0}},
    '{32'h5A5A_A5A5, 16'h8000, 1'b0, '{default: '0}},
    '{32'h8000_0000, 16'h7FFF, 1'b0, '{default: '0}}
  };

  // offer stream, filled before the drive process starts
  logic [ID_W-1:0]   offer_ids [$];
  logic [PRIO_W-1:0] offer_prios [$];

  task automatic queue_offer(input logic [ID_W-1:0] id, input logic [PRIO_W-1:0] prio);
    offer_ids.push_back(id);
    offer_prios.push_back(prio);
  endtask

  function automatic logic [ID_W-1:0] random_id();
    if (id_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
    return $urandom();
  endfunction

  // random traffic in rounds: fill to full, then hammer a full list, then a fresh pool
  task automatic build_random_stream();
    int made;
    logic [ID_W-1:0] id;
    made = 0;
    while (made < N_RANDOM) begin
      id_pool.delete();
      for (int k = 0; k < 110 && made < N_RANDOM; k++) begin
        case ($urandom_range(0, 9))
          0: id = $urandom();
          1: id = (k % 2) ? '1 : '0;
          default: id = random_id();
        endcase
        if (id_pool.size() < 80) id_pool.push_back(id);
        // narrow priorities make ties frequent
        if ($urandom_range(0, 1)) queue_offer(id, PRIO_W'($urandom_range(0, 15)));
        else queue_offer(id, PRIO_W'($urandom_range(0, 16'hFFFF)));
        made++;
      end
    end
  endtask

  // the core has no clear, so drain the list between rounds is not possible;
  // the pool restarts instead and the list stays full with new ids dropped

  // sender
  initial begin
    int gap;
    in_ch.valid        = 1'b0;
    in_ch.node_id      = '0;
    in_ch.priority_req = '0;
    inputs_done        = 1'b0;
    shadow_count       = 0;
    error_count        = 0;
    foreach (directed[i]) queue_offer(directed[i].id, directed[i].prio);
    build_random_stream();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int n = 0; n < offer_ids.size(); n++) begin
      // no idle stretch for a while every few hundred offers
      gap = ((n / 150) % 3 == 1) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid        <= 1'b1;
      in_ch.node_id      <= offer_ids[n];
      in_ch.priority_req <= offer_prios[n];
      do @(posedge clk); while (!in_ch.ready);
      // transfer accepted: predict now
      if (n < directed.size() && directed[n].typed) begin
        void'(apply_offer(offer_ids[n], offer_prios[n]));
        expected_results.push_back(directed[n].want);
      end else begin
        expected_results.push_back(apply_offer(offer_ids[n], offer_prios[n]));
      end
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
    inputs_done = 1'b1;
  end

  // receiver, with one long hold-off counted here
  initial begin
    int stall;
    int results_seen;
    out_ch.ready = 1'b0;
    long_holdoff = 1'b0;
    results_seen = 0;
    @(negedge clk);
    while (1) begin
      if (results_seen == 40 && !long_holdoff) begin
        long_holdoff = 1'b1;
        stall = 300;
      end else begin
        stall = ((results_seen / 200) % 3 == 2) ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results_seen++;
      @(negedge clk);
    end
  end

  // checker: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_ch.status), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 64'(out_ch.status), 64'(want.status));
        if (out_ch.head_node !== want.head_node)
          report_mismatch("head_node", 64'(out_ch.head_node), 64'(want.head_node));
        if (out_ch.head_priority !== want.head_priority)
          report_mismatch("head_priority", 64'(out_ch.head_priority),
                          64'(want.head_priority));
        if (out_ch.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(out_ch.entry_count), 64'(want.entry_count));
      end
    end
  end

  // run control: drain, let latency pass, then decide; cycle limit as a backstop
  initial begin
    cycle_count = 0;
    while (!(inputs_done && expected_results.size() == 0) && cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    if (cycle_count >= MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
    end else begin
      repeat (20) @(posedge clk);
      if (error_count == 0 && expected_results.size() == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
    end
    $finish;
  end

endmodule
